>>> rtl/alifd_pkg.sv
// ----------------------------------------------------------------------------
// alifd_pkg: shared types and codes for the array list block
// Operation kinds, result status codes and the fixed widths of the transfer
// payloads.
// ----------------------------------------------------------------------------
package alifd_pkg;

	// payload field widths
	localparam int unsigned KindW   = 2;
	localparam int unsigned PosW    = 7;
	localparam int unsigned WordW   = 32;
	localparam int unsigned StatusW = 2;
	localparam int unsigned IdxW    = 6;
	localparam int unsigned CountW  = 7;

	typedef logic [KindW-1:0]   kind_t;
	typedef logic [StatusW-1:0] status_t;
	typedef logic [PosW-1:0]    pos_t;
	typedef logic [IdxW-1:0]    idx_t;
	typedef logic [CountW-1:0]  cnt_t;

	// operation kinds
	localparam kind_t KIND_INSERT = 2'd0;
	localparam kind_t KIND_READ   = 2'd1;
	localparam kind_t KIND_FIND   = 2'd2;
	localparam kind_t KIND_DELETE = 2'd3;

	// result status codes
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_NOT_FOUND = 2'd1;
	localparam status_t ST_BAD_POS   = 2'd2;
	localparam status_t ST_FULL      = 2'd3;

endpackage

>>> rtl/alifd_req_if.sv
// ----------------------------------------------------------------------------
// alifd_req_if: operation request channel
// Valid/ready channel carrying one list operation per transfer.
// ----------------------------------------------------------------------------
interface alifd_req_if;
	logic                  valid;
	logic                  ready;
	alifd_pkg::kind_t      kind;
	alifd_pkg::pos_t       position;
	logic signed [31:0]    value;

	modport source (output valid, output kind, output position, output value, input ready);
	modport sink (input valid, input kind, input position, input value, output ready);
endinterface

>>> rtl/alifd_rsp_if.sv
// ----------------------------------------------------------------------------
// alifd_rsp_if: operation result channel
// Valid/ready channel carrying one result per operation.
// ----------------------------------------------------------------------------
interface alifd_rsp_if;
	logic                  valid;
	logic                  ready;
	alifd_pkg::status_t    status;
	logic signed [31:0]    read_value;
	alifd_pkg::idx_t       found_index;
	alifd_pkg::cnt_t       entry_count;

	modport source (output valid, output status, output read_value, output found_index,
		output entry_count, input ready);
	modport sink (input valid, input status, input read_value, input found_index,
		input entry_count, output ready);
endinterface

>>> rtl/alifd_ram.sv
// ----------------------------------------------------------------------------
// alifd_ram: generic single-write, single-read memory
// One write port and one read port, read data registered. No reset on data.
// ----------------------------------------------------------------------------
module alifd_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/array_list_insert_find_delete.sv
// ----------------------------------------------------------------------------
// array_list_insert_find_delete: dense list of signed words with a count
// Insert at position, read at position, find last match, delete first match.
// ----------------------------------------------------------------------------
// Usage
//   req: one operation per transfer (kind, position, value). The block takes a
//   request only when its sequencer is idle; a transfer starts a walk through
//   the list memory with one read port and one write port.
//   rsp: one result per request (status, read_value, found_index, entry_count),
//   held in an output register until the receiver takes it.
// Operation steps:
//   read fetches one entry; insert shifts the entries from its position up,
//   or only stores the word for an append; find scans down from the last
//   entry; delete scans up from the first, then shifts later entries down.
//   One entry is moved or compared per cycle through the single read port.
// A new request is taken as soon as the sequencer is idle, even while a result
// waits in the output register; a finished operation then waits until that
// register is free, so a stalled receiver stops the block with one result
// offered and one more finished operation held.
// Reset clears the count, the sequencer and the output register at once; the
// list memory is not cleared, only entries below the count are ever read.
// ----------------------------------------------------------------------------
module array_list_insert_find_delete #(
	parameter int unsigned DEPTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	alifd_req_if.sink     req,
	alifd_rsp_if.source   rsp
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned MW = (CW > alifd_pkg::PosW) ? CW : alifd_pkg::PosW;

	// sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_RDW   = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_SHUP  = 3'd4;
	localparam logic [2:0] S_SHDN  = 3'd5;
	localparam logic [2:0] S_PUT   = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0]                state_q;
	logic [CW-1:0]             count_q;
	logic [AW-1:0]             a_q;
	logic [CW-1:0]             n_q;
	logic                      rv_q;
	logic [AW-1:0]             ra_q;

	alifd_pkg::kind_t          kind_q;
	alifd_pkg::pos_t           pos_q;
	logic [31:0]               val_q;
	alifd_pkg::status_t        status_q;
	logic [31:0]               rd_q;
	logic [AW-1:0]             idx_q;

	logic                      ovalid_q;
	alifd_pkg::status_t        ostatus_q;
	logic [31:0]               ordval_q;
	alifd_pkg::idx_t           oidx_q;
	alifd_pkg::cnt_t           ocount_q;

	logic                      ram_we;
	logic [AW-1:0]             ram_waddr;
	logic [31:0]               ram_wdata;
	logic                      ram_re;
	logic [AW-1:0]             ram_raddr;
	logic [31:0]               ram_rdata;

	logic                      hit;
	logic                      walk;
	logic                      out_free;
	logic                      pos_gt_count;
	logic                      pos_ge_count;
	logic                      last_entry;

	// list store
	alifd_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// shared compare and position checks
	assign hit          = rv_q && (ram_rdata == val_q);
	assign pos_gt_count = MW'(pos_q) > MW'(count_q);
	assign pos_ge_count = MW'(pos_q) >= MW'(count_q);
	assign last_entry   = (CW'(ra_q) + CW'(1)) == count_q;
	assign walk         = (state_q == S_SCAN) || (state_q == S_SHUP) || (state_q == S_SHDN);
	assign out_free     = !ovalid_q || rsp.ready;

	// memory read: the position for a read, otherwise the walking address
	always_comb begin
		ram_raddr = a_q;
		ram_re    = 1'b0;
		if (state_q == S_CHECK) begin
			ram_raddr = AW'(pos_q);
			ram_re    = (kind_q == alifd_pkg::KIND_READ) && !pos_ge_count;
		end else if (walk) begin
			ram_re = (n_q != '0) && !((state_q == S_SCAN) && hit);
		end
	end

	// memory write: shifted entry one place up or down, or the new word
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ra_q + AW'(1);
		ram_wdata = ram_rdata;
		case (state_q)
			S_SHUP: begin
				ram_we = rv_q;
			end
			S_SHDN: begin
				ram_we    = rv_q;
				ram_waddr = ra_q - AW'(1);
			end
			S_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(pos_q);
				ram_wdata = val_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			n_q     <= '0;
			rv_q    <= 1'b0;
		end else begin
			rv_q <= ram_re;
			if (ram_re && walk) begin
				n_q <= n_q - CW'(1);
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					state_q <= S_DONE;
					case (kind_q)
						alifd_pkg::KIND_INSERT: begin
							if (count_q != CW'(DEPTH) && !pos_gt_count) begin
								n_q     <= count_q - CW'(pos_q);
								state_q <= pos_ge_count ? S_PUT : S_SHUP;
							end
						end
						alifd_pkg::KIND_READ: begin
							if (!pos_ge_count) begin
								state_q <= S_RDW;
							end
						end
						default: begin
							if (count_q != '0) begin
								n_q     <= count_q;
								state_q <= S_SCAN;
							end
						end
					endcase
				end
				S_RDW: begin
					state_q <= S_DONE;
				end
				S_SCAN: begin
					if (hit) begin
						if (kind_q == alifd_pkg::KIND_FIND) begin
							state_q <= S_DONE;
						end else if (last_entry) begin
							count_q <= count_q - CW'(1);
							state_q <= S_DONE;
						end else begin
							n_q     <= count_q - CW'(ra_q) - CW'(1);
							state_q <= S_SHDN;
						end
					end else if (rv_q && n_q == '0) begin
						state_q <= S_DONE;
					end
				end
				S_SHUP: begin
					if (rv_q && n_q == '0) begin
						state_q <= S_PUT;
					end
				end
				S_SHDN: begin
					if (rv_q && n_q == '0) begin
						count_q <= count_q - CW'(1);
						state_q <= S_DONE;
					end
				end
				S_PUT: begin
					count_q <= count_q + CW'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// operation registers and walking address
	always_ff @(posedge clk) begin
		ra_q <= ram_raddr;
		if (ram_re && walk) begin
			if (state_q == S_SHDN || (state_q == S_SCAN && kind_q == alifd_pkg::KIND_DELETE)) begin
				a_q <= a_q + AW'(1);
			end else begin
				a_q <= a_q - AW'(1);
			end
		end
		case (state_q)
			S_IDLE: begin
				kind_q   <= req.kind;
				pos_q    <= req.position;
				val_q    <= req.value;
				status_q <= alifd_pkg::ST_OK;
				rd_q     <= '0;
				idx_q    <= '0;
			end
			S_CHECK: begin
				case (kind_q)
					alifd_pkg::KIND_INSERT: begin
						a_q <= AW'(count_q - CW'(1));
						if (count_q == CW'(DEPTH)) begin
							status_q <= alifd_pkg::ST_FULL;
						end else if (pos_gt_count) begin
							status_q <= alifd_pkg::ST_BAD_POS;
						end
					end
					alifd_pkg::KIND_READ: begin
						if (pos_ge_count) begin
							status_q <= alifd_pkg::ST_BAD_POS;
						end
					end
					alifd_pkg::KIND_FIND: begin
						a_q <= AW'(count_q - CW'(1));
						if (count_q == '0) begin
							status_q <= alifd_pkg::ST_NOT_FOUND;
						end
					end
					default: begin
						a_q <= '0;
						if (count_q == '0) begin
							status_q <= alifd_pkg::ST_NOT_FOUND;
						end
					end
				endcase
			end
			S_RDW: begin
				rd_q <= ram_rdata;
			end
			S_SCAN: begin
				if (hit) begin
					idx_q <= ra_q;
					a_q   <= ra_q + AW'(1);
				end else if (rv_q && n_q == '0) begin
					status_q <= alifd_pkg::ST_NOT_FOUND;
				end
			end
			default: begin
				rd_q <= rd_q;
			end
		endcase
	end

	// output register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			ovalid_q <= 1'b1;
		end else if (rsp.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	// output register: payload
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			ostatus_q <= status_q;
			ordval_q  <= rd_q;
			oidx_q    <= alifd_pkg::IdxW'(idx_q);
			ocount_q  <= alifd_pkg::CountW'(count_q);
		end
	end

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = ovalid_q;
	assign rsp.status      = ostatus_q;
	assign rsp.read_value  = ordval_q;
	assign rsp.found_index = oidx_q;
	assign rsp.entry_count = ocount_q;

`ifndef SYNTHESIS
	// count never passes the list depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("count beyond depth");

	// a shift never reads and writes the same entry in one cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("read and write to the same entry");

	// storing the new word grows the list by one
	a_put_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUT) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not grow the list");

	// a finished result waits while the output register is still occupied
	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && ovalid_q && !rsp.ready) |=> (state_q == S_DONE && ovalid_q))
		else $error("result dropped while receiver stalled");
`endif

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for array_list_insert_find_delete
// Drives insert, read, find and delete operations over the request channel
// and keeps its own copy of the list and count. It works out the result of
// each accepted operation and checks every result transfer against the oldest
// outstanding one. Directed corner cases come first. Random traffic follows,
// in grow, balanced and shrink phases, with bursty requests and a stalling
// receiver.
// ----------------------------------------------------------------------------
module tb;

	localparam int unsigned LIST_DEPTH  = 64;
	localparam int          RAND_OPS    = 1000;
	localparam int          PHASE_OPS   = 150;
	localparam int          SETTLE_CYC  = 2 * LIST_DEPTH + 16;
	localparam int          HOLD_CYC    = 400;
	localparam int          CYCLE_LIMIT = 1000000;
	localparam int          SHOW_ERRORS = 10;

	// random traffic mixes and receiver behaviour per segment
	typedef enum int {MIX_GROW, MIX_BALANCED, MIX_SHRINK} mix_t;
	typedef enum int {RX_ALWAYS, RX_COIN, RX_PATTERN} rx_mode_t;

	// one result as seen on the result channel
	typedef struct {
		alifd_pkg::status_t status;
		logic [31:0]        read_value;
		alifd_pkg::idx_t    found_index;
		alifd_pkg::cnt_t    entry_count;
	} list_rsp_t;

	// list copy, expected results and error bookkeeping
	class list_scoreboard;
		logic [31:0]  words [LIST_DEPTH];
		int unsigned  fill;
		int unsigned  peak_fill;
		list_rsp_t    pending_results [$];
		int           n_errors;
		int           n_checked;
		int           n_status [4];

		function new();
			fill      = 0;
			peak_fill = 0;
			n_errors  = 0;
			n_checked = 0;
			foreach (n_status[i]) n_status[i] = 0;
		endfunction

		function int unsigned fill_level();
			return fill;
		endfunction

		function logic [31:0] entry_at(int unsigned i);
			return words[i];
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		// apply one operation to the list copy and return its result
		function list_rsp_t apply_list_op(alifd_pkg::kind_t k, alifd_pkg::pos_t p,
				logic [31:0] w);
			list_rsp_t   r;
			int unsigned i;
			int unsigned hit_idx;
			bit          hit;
			r.status      = alifd_pkg::ST_OK;
			r.read_value  = '0;
			r.found_index = '0;
			hit           = 1'b0;
			hit_idx       = 0;
			case (k)
				alifd_pkg::KIND_INSERT: begin
					// full check comes before the position check
					if (fill >= LIST_DEPTH) begin
						r.status = alifd_pkg::ST_FULL;
					end else if (p > fill) begin
						r.status = alifd_pkg::ST_BAD_POS;
					end else begin
						for (i = fill; i > p; i--) words[i] = words[i-1];
						words[p] = w;
						fill++;
					end
				end
				alifd_pkg::KIND_READ: begin
					if (p >= fill) r.status = alifd_pkg::ST_BAD_POS;
					else r.read_value = words[p];
				end
				alifd_pkg::KIND_FIND: begin
					// last match wins
					for (i = 0; i < fill; i++) begin
						if (words[i] === w) begin
							hit     = 1'b1;
							hit_idx = i;
						end
					end
					if (hit) r.found_index = alifd_pkg::idx_t'(hit_idx);
					else r.status = alifd_pkg::ST_NOT_FOUND;
				end
				default: begin
					// first match is removed, later entries move down
					for (i = 0; i < fill; i++) begin
						if (words[i] === w) begin
							hit     = 1'b1;
							hit_idx = i;
							break;
						end
					end
					if (!hit) begin
						r.status = alifd_pkg::ST_NOT_FOUND;
					end else begin
						r.found_index = alifd_pkg::idx_t'(hit_idx);
						for (i = hit_idx; i + 1 < fill; i++) words[i] = words[i+1];
						fill--;
					end
				end
			endcase
			r.entry_count = alifd_pkg::cnt_t'(fill);
			if (fill > peak_fill) peak_fill = fill;
			return r;
		endfunction

		// an operation transfer was accepted
		function void note_op(alifd_pkg::kind_t k, alifd_pkg::pos_t p, logic [31:0] w);
			pending_results.push_back(apply_list_op(k, p, w));
		endfunction

		// a result transfer was accepted
		function void check_result(list_rsp_t got);
			list_rsp_t want;
			n_checked++;
			if (pending_results.size() == 0) begin
				n_errors++;
				if (n_errors <= SHOW_ERRORS)
					$display("result %0d arrived with no operation outstanding: status %0d",
						n_checked, got.status);
				return;
			end
			want = pending_results.pop_front();
			n_status[want.status]++;
			if (got.status !== want.status || got.read_value !== want.read_value ||
					got.found_index !== want.found_index ||
					got.entry_count !== want.entry_count) begin
				n_errors++;
				if (n_errors <= SHOW_ERRORS) begin
					$display("result %0d wrong: expected status %0d read %h index %0d count %0d",
						n_checked, want.status, want.read_value, want.found_index,
						want.entry_count);
					$display("  got status %0d read %h index %0d count %0d",
						got.status, got.read_value, got.found_index, got.entry_count);
				end
			end
		endfunction

		// results that never came
		function void flag_leftovers();
			if (pending_results.size() != 0) begin
				$display("%0d results still outstanding at the end", pending_results.size());
				n_errors += pending_results.size();
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   n_sent;

	list_scoreboard sb;

	alifd_req_if req_ch ();
	alifd_rsp_if rsp_ch ();

	array_list_insert_find_delete #(
		.DEPTH (LIST_DEPTH)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		int cycle_cnt;
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("run stopped after %0d cycles without finishing", cycle_cnt);
		$display("Mismatches found");
		$finish;
	end

	// offer one operation and wait for its transfer
	task automatic push_op(alifd_pkg::kind_t k, alifd_pkg::pos_t p, logic [31:0] w);
		req_ch.valid    <= 1'b1;
		req_ch.kind     <= k;
		req_ch.position <= p;
		req_ch.value    <= w;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sb.note_op(k, p, w);
		n_sent++;
	endtask

	// drop valid for a number of cycles
	task automatic idle_req(int cycles);
		req_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// stop offering until every result is in
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// word from a short pool of extremes and repeats
	function automatic logic [31:0] pool_word();
		case ($urandom_range(0, 5))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h7FFF_FFFF;
			3: return 32'h8000_0000;
			4: return 32'h0000_0001;
			default: return 32'h55AA_55AA;
		endcase
	endfunction

	// word that is likely to be in the list
	function automatic logic [31:0] search_word();
		int unsigned lvl;
		int unsigned roll;
		lvl  = sb.fill_level();
		roll = $urandom_range(0, 9);
		if (lvl > 0 && roll < 6) return sb.entry_at($urandom_range(0, lvl - 1));
		if (roll < 8) return pool_word();
		return $urandom;
	endfunction

	// choose one random operation for the current mix
	task automatic pick_op(mix_t mix, output alifd_pkg::kind_t k, output alifd_pkg::pos_t p,
			output logic [31:0] w);
		int unsigned lvl;
		int unsigned roll;
		lvl  = sb.fill_level();
		roll = $urandom_range(0, 99);
		case (mix)
			MIX_GROW:     k = roll < 80 ? alifd_pkg::KIND_INSERT : roll < 90 ?
				alifd_pkg::KIND_READ : roll < 95 ? alifd_pkg::KIND_FIND :
				alifd_pkg::KIND_DELETE;
			MIX_SHRINK:   k = roll < 15 ? alifd_pkg::KIND_INSERT : roll < 30 ?
				alifd_pkg::KIND_READ : roll < 45 ? alifd_pkg::KIND_FIND :
				alifd_pkg::KIND_DELETE;
			default:      k = roll < 35 ? alifd_pkg::KIND_INSERT : roll < 60 ?
				alifd_pkg::KIND_READ : roll < 80 ? alifd_pkg::KIND_FIND :
				alifd_pkg::KIND_DELETE;
		endcase
		case (k)
			alifd_pkg::KIND_INSERT: begin
				p = ($urandom_range(0, 99) < 85) ? alifd_pkg::pos_t'($urandom_range(0, lvl)) :
					alifd_pkg::pos_t'($urandom_range(0, 127));
				w = ($urandom_range(0, 9) < 6) ? pool_word() : 32'($urandom);
				if ($urandom_range(0, 9) >= 6) w = $urandom;
			end
			alifd_pkg::KIND_READ: begin
				p = (lvl > 0 && $urandom_range(0, 99) < 85) ?
					alifd_pkg::pos_t'($urandom_range(0, lvl - 1)) :
					alifd_pkg::pos_t'($urandom_range(0, 127));
				w = $urandom;
			end
			default: begin
				p = alifd_pkg::pos_t'($urandom_range(0, 127));
				w = search_word();
			end
		endcase
	endtask

	// request side: reset, directed cases, random traffic, end of run
	initial begin
		alifd_pkg::kind_t k;
		alifd_pkg::pos_t  p;
		logic [31:0]      w;
		int               burst_left;
		int               gap;
		mix_t             mix;
		sb              = new();
		n_sent          = 0;
		arst_n          = 1'b0;
		req_ch.valid    <= 1'b0;
		req_ch.kind     <= alifd_pkg::KIND_READ;
		req_ch.position <= '0;
		req_ch.value    <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list: every operation fails
		push_op(alifd_pkg::KIND_READ,   7'd0,   32'h0000_0000);
		push_op(alifd_pkg::KIND_FIND,   7'd0,   32'h0000_0000);
		push_op(alifd_pkg::KIND_DELETE, 7'd0,   32'h0000_0000);
		push_op(alifd_pkg::KIND_INSERT, 7'd1,   32'h1234_5678);
		// build -1, 0, max, min, -1 with front, middle and end inserts
		push_op(alifd_pkg::KIND_INSERT, 7'd0,   32'h7FFF_FFFF);
		push_op(alifd_pkg::KIND_INSERT, 7'd1,   32'h8000_0000);
		push_op(alifd_pkg::KIND_INSERT, 7'd0,   32'hFFFF_FFFF);
		push_op(alifd_pkg::KIND_INSERT, 7'd1,   32'h0000_0000);
		push_op(alifd_pkg::KIND_INSERT, 7'd5,   32'h0000_0005);
		push_op(alifd_pkg::KIND_INSERT, 7'd4,   32'hFFFF_FFFF);
		// reads in and out of range
		push_op(alifd_pkg::KIND_READ,   7'd0,   32'hFFFF_FFFF);
		push_op(alifd_pkg::KIND_READ,   7'd4,   32'h0000_0000);
		push_op(alifd_pkg::KIND_READ,   7'd5,   32'h0000_0000);
		push_op(alifd_pkg::KIND_READ,   7'd64,  32'h0000_0000);
		push_op(alifd_pkg::KIND_READ,   7'd127, 32'h0000_0000);
		// find takes the last match, compares all bits
		push_op(alifd_pkg::KIND_FIND,   7'd127, 32'hFFFF_FFFF);
		push_op(alifd_pkg::KIND_FIND,   7'd3,   32'h8000_0000);
		push_op(alifd_pkg::KIND_FIND,   7'd0,   32'h7FFF_FFFE);
		push_op(alifd_pkg::KIND_FIND,   7'd64,  32'h0001_2345);
		// delete takes the first match
		push_op(alifd_pkg::KIND_DELETE, 7'd127, 32'hFFFF_FFFF);
		push_op(alifd_pkg::KIND_READ,   7'd0,   32'h0000_0000);
		push_op(alifd_pkg::KIND_DELETE, 7'd0,   32'h0000_002A);
		push_op(alifd_pkg::KIND_DELETE, 7'd0,   32'h8000_0000);
		push_op(alifd_pkg::KIND_READ,   7'd2,   32'h0000_0000);
		drain_results();

		// random traffic in bursts, phases cycle grow, balanced, shrink
		burst_left = $urandom_range(1, 30);
		for (int i = 0; i < RAND_OPS; i++) begin
			case ((i / PHASE_OPS) % 3)
				0:       mix = MIX_GROW;
				1:       mix = MIX_BALANCED;
				default: mix = MIX_SHRINK;
			endcase
			if (i == RAND_OPS / 2) drain_results();
			pick_op(mix, k, p, w);
			push_op(k, p, w);
			burst_left--;
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				if (gap > 0) idle_req(gap);
				burst_left = $urandom_range(1, 30);
			end
		end

		// wait out the tail
		drain_results();
		repeat (SETTLE_CYC) @(posedge clk);
		sb.flag_leftovers();

		$display("ran %0d operations: %0d ok, %0d not found, %0d bad position, %0d full",
			n_sent, sb.n_status[alifd_pkg::ST_OK], sb.n_status[alifd_pkg::ST_NOT_FOUND],
			sb.n_status[alifd_pkg::ST_BAD_POS], sb.n_status[alifd_pkg::ST_FULL]);
		$display("list peaked at %0d entries, %0d results checked, %0d failures",
			sb.peak_fill, sb.n_checked, sb.n_errors);
		if (sb.n_errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// result side: check each transfer, stall on a pattern of its own
	initial begin
		rx_mode_t  rx_mode;
		logic [7:0] pat;
		int        seg_left;
		int        hold_left;
		int        holds_done;
		int        phase;
		logic      nxt_ready;
		list_rsp_t got;
		rsp_ch.ready <= 1'b0;
		seg_left   = 0;
		hold_left  = 0;
		holds_done = 0;
		phase      = 0;
		rx_mode    = RX_ALWAYS;
		pat        = 8'hFF;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			// check a result transfer at this edge
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				got.status      = rsp_ch.status;
				got.read_value  = rsp_ch.read_value;
				got.found_index = rsp_ch.found_index;
				got.entry_count = rsp_ch.entry_count;
				sb.check_result(got);
			end
			// long hold-offs while requests keep coming
			if ((holds_done == 0 && n_sent >= 300) || (holds_done == 1 && n_sent >= 800)) begin
				hold_left = HOLD_CYC;
				holds_done++;
			end
			// new segment mode every so often
			if (seg_left == 0) begin
				case ($urandom_range(0, 2))
					0:       rx_mode = RX_ALWAYS;
					1:       rx_mode = RX_COIN;
					default: rx_mode = RX_PATTERN;
				endcase
				pat      = 8'($urandom);
				seg_left = $urandom_range(20, 80);
			end
			seg_left--;
			phase++;
			if (hold_left > 0) begin
				hold_left--;
				nxt_ready = 1'b0;
			end else begin
				case (rx_mode)
					RX_ALWAYS: nxt_ready = 1'b1;
					RX_COIN:   nxt_ready = 1'($urandom_range(0, 1));
					default:   nxt_ready = pat[phase % 8];
				endcase
			end
			rsp_ch.ready <= nxt_ready;
		end
	end

endmodule
